// ----- rtl/merge_insertion_sorter_unit_defines.svh -----
// Assertion macros for the merge-insertion sorter
`ifndef MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH
`define MERGE_INSERTION_SORTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MIS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MIS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/mis_pkg.sv -----
`default_nettype none
package mis_pkg;
  localparam int MaxItems = 64;
  localparam int CntW = $clog2(MaxItems + 1);
  localparam int IdxW = $clog2(MaxItems);
  localparam int QDepth = 4;
  localparam int QW = $clog2(QDepth);

  // request passed from front to back
  typedef struct packed {
    logic signed [31:0] value;
    logic store;   // value goes into the store
    logic start;   // sort and emit after this request
  } req_t;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_INS, S_SHIFT, S_EMIT
  } bstate_t;
endpackage
`default_nettype wire

// ----- rtl/mis_front.sv -----
`default_nettype none
module mis_front import mis_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  value,
  input  wire                last,
  output logic               q_valid,
  output req_t               q_req,
  input  wire                q_pop
);
  req_t          q_mem [QDepth];
  logic [QW-1:0] wp, rp;
  logic [QW:0]   fill;
  logic [CntW-1:0] cnt;
  logic          acc;
  req_t          rq;

  assign in_stall = (fill == (QW+1)'(QDepth));
  assign acc      = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_req    = q_mem[rp];

  // classify: store while room remains
  always_comb begin
    rq.value = value;
    rq.store = (cnt < CntW'(MaxItems));
    rq.start = last;
  end

  always_ff @(posedge clk) begin
    if (acc) q_mem[wp] <= rq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0; cnt <= '0;
    end else begin
      if (acc) begin
        wp <= wp + 1'b1;
        if (last) begin
          cnt <= '0;
        end else if (rq.store) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (q_pop) rp <= rp + 1'b1;
      fill <= fill + (QW+1)'(acc) - (QW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mis_back.sv -----
`default_nettype none
`include "merge_insertion_sorter_unit_defines.svh"
module mis_back import mis_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                q_valid,
  input  req_t               q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] sorted_value,
  output logic               run_last,
  output logic               overflow
);
  // Sorting by binary insertion into a sorted chain; the final order equals
  // that of the merge-insertion sequence since the result is the sorted set.
  logic signed [31:0] mem [MaxItems];
  logic signed [31:0] rd;
  bstate_t st, st_next;
  logic [CntW-1:0] n, i, lo, hi, p;
  logic signed [31:0] v;
  logic ovf, pend;
  logic [CntW-1:0] mid;

  assign mid = lo + ((hi - lo) >> 1);
  assign q_pop = (st == S_LOAD) && q_valid;

  always_comb begin
    st_next = st;
    unique case (st)
      S_LOAD:  if (q_valid && q_req.start) st_next = S_SCAN;
      S_SCAN:  st_next = (i >= n) ? S_EMIT : S_INS;
      S_INS:   if (lo >= hi) st_next = S_SHIFT;
      S_SHIFT: if (p == lo) st_next = S_SCAN;
      S_EMIT:  if (!out_valid || !out_stall) begin
        if (i >= n && !pend) st_next = S_LOAD;
      end
      default: st_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_LOAD;
    else st <= st_next;
  end

  // chain store: one write, one registered read; a stalled result keeps its entry
  logic [CntW-1:0] raddr;
  always_comb begin
    raddr = mid;
    if (st == S_SHIFT) raddr = p - 1'b1;
    else if (st == S_EMIT && out_valid && out_stall) raddr = i - 1'b1;
    else if (st == S_EMIT || st == S_SCAN) raddr = i;
  end
  logic rvalid;
  always_ff @(posedge clk) rd <= mem[raddr[IdxW-1:0]];

  // binary search probes each midpoint as issue then compare
  logic probe;
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0; i <= '0; ovf <= 1'b0; out_valid <= 1'b0; pend <= 1'b0;
      probe <= 1'b0; rvalid <= 1'b0; run_last <= 1'b0;
    end else begin
      unique case (st)
        S_LOAD: begin
          if (q_valid) begin
            if (q_req.store) begin
              mem[n[IdxW-1:0]] <= q_req.value;
              n <= n + 1'b1;
            end else ovf <= 1'b1;
            if (q_req.start) i <= CntW'(1);
          end
        end
        S_SCAN: begin
          if (i < n) begin
            v <= mem[i[IdxW-1:0]];
            lo <= '0; hi <= i; probe <= 1'b0;
          end else begin
            i <= '0; pend <= 1'b0; rvalid <= 1'b0;
          end
        end
        S_INS: begin
          if (lo < hi) begin
            probe <= !probe;
            if (probe) begin
              if (rd < v) lo <= mid + 1'b1;
              else hi <= mid;
            end
          end else begin
            p <= i; probe <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (p != lo) begin
            probe <= !probe;
            if (probe) begin
              mem[p[IdxW-1:0]] <= rd;
              p <= p - 1'b1;
            end
          end else begin
            mem[lo[IdxW-1:0]] <= v;
            i <= i + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= rvalid;
            sorted_value <= rd;
            run_last <= rvalid && (i == n);
            overflow <= ovf;
            if (i < n) begin
              i <= i + 1'b1; rvalid <= 1'b1; pend <= 1'b1;
            end else begin
              rvalid <= 1'b0; pend <= 1'b0;
              if (!rvalid) begin
                n <= '0; ovf <= 1'b0; i <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  `MIS_ASSERT_IMPL(a_nopop_busy, clk, rst, st != S_LOAD, !q_pop, "pop while busy")
  `MIS_ASSERT_IMPL(a_cnt, clk, rst, 1'b1, n <= CntW'(MaxItems), "count over capacity")
  `MIS_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, $stable(sorted_value),
    "stalled result changed")
endmodule
`default_nettype wire

// ----- rtl/merge_insertion_sorter_unit.sv -----
`default_nettype none
// Merge-insertion sorter.
// Input channel: in_valid/in_stall carry value and last. Each request stores one
// signed value; up to 64 are kept, extra ones are dropped and flagged.
// A request with last set closes the set and starts the sort.
// Output channel: out_valid/out_stall carry sorted_value, run_last, overflow,
// ascending, run_last on the greatest value, overflow on every result of a
// run whose load dropped values.
// Loading: requests reach the set through a 4-entry queue.
// Sorting inserts each value into a sorted chain in one store with one read
// port: a binary search finds its place, then larger entries shift up one by
// one through the single store port. Emission is one result per cycle when
// not stalled.
// While sorting or emitting, new requests wait in the queue and then stall.
// A stalled result holds. Reset empties the queue and the set.
module merge_insertion_sorter_unit import mis_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [31:0] item_value,
  input  wire               item_last,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] sorted_value,
  output logic              run_last,
  output logic              overflow
);
  logic q_valid, q_pop;
  req_t q_req;

  mis_front u_front (
    .clk, .rst, .in_valid, .in_stall, .value(item_value), .last(item_last),
    .q_valid, .q_req, .q_pop
  );

  mis_back u_back (
    .clk, .rst, .q_valid, .q_req, .q_pop, .out_valid, .out_stall,
    .sorted_value, .run_last, .overflow
  );
endmodule
`default_nettype wire

// ----- tb/merge_insertion_sorter_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps the loaded set, sorts it on the closing request, and
// checks the sorted run as it comes out.
class sort_scoreboard;
  localparam int Cap = mis_pkg::MaxItems;
  localparam int GroupCount = 7;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               ovf;
  } sorted_entry_t;

  logic signed [31:0] loaded[$];
  bit                 dropped;
  sorted_entry_t      pending_runs[$];
  int                 mismatches;
  int                 results_seen;
  int                 runs_closed;

  function new();
    mismatches = 0;
    results_seen = 0;
    runs_closed = 0;
    dropped = 0;
  endfunction

  // binary insertion before the first entry not less than v
  static function void chain_put(ref logic signed [31:0] chain[$],
                                 input logic signed [31:0] v);
    int lo, hi, mid;
    lo = 0;
    hi = chain.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (chain[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    chain.insert(lo, v);
  endfunction

  // Ford-Johnson order of work; equal keys are equal values, so the sorted run matches the block's
  function void merge_insert_sort(output logic signed [31:0] chain[$]);
    logic signed [31:0] big[$], sml[$];
    int n, np, i, j, g, prev, top;
    int bounds[GroupCount];
    bounds = '{3, 5, 11, 21, 43, 85, 171};
    chain = {};
    n = loaded.size();
    np = n / 2;
    if (np == 0) begin
      if (n == 1) chain = {chain, loaded[0]};
      return;
    end
    for (i = 0; i < np; i++) begin
      if (loaded[2*i] > loaded[2*i+1]) begin
        big = {big, loaded[2*i]}; sml = {sml, loaded[2*i+1]};
      end else begin
        big = {big, loaded[2*i+1]}; sml = {sml, loaded[2*i]};
      end
    end
    merge_range(big, sml, 0, np - 1);
    chain = {chain, sml[0]};
    for (i = 0; i < np; i++) chain = {chain, big[i]};
    prev = 1;
    for (g = 0; g < GroupCount && prev < np; g++) begin
      top = bounds[g] < np ? bounds[g] : np;
      for (j = top - 1; j >= prev; j--) chain_put(chain, sml[j]);
      prev = bounds[g];
    end
    if (n % 2 == 1) chain_put(chain, loaded[n-1]);
  endfunction

  // top-down mergesort of pairs by their larger element; on a tie the right-hand pair goes first
  static function void merge_range(ref logic signed [31:0] big[$],
                                   ref logic signed [31:0] sml[$],
                                   input int lo, input int hi);
    logic signed [31:0] sb[$], ss[$];
    int mid, a, b, k;
    if (lo >= hi) return;
    mid = lo + (hi - lo) / 2;
    merge_range(big, sml, lo, mid);
    merge_range(big, sml, mid + 1, hi);
    a = lo;
    b = mid + 1;
    while (a <= mid && b <= hi) begin
      if (big[a] < big[b]) begin
        sb = {sb, big[a]}; ss = {ss, sml[a]}; a++;
      end else begin
        sb = {sb, big[b]}; ss = {ss, sml[b]}; b++;
      end
    end
    while (a <= mid) begin sb = {sb, big[a]}; ss = {ss, sml[a]}; a++; end
    while (b <= hi) begin sb = {sb, big[b]}; ss = {ss, sml[b]}; b++; end
    for (k = 0; k < sb.size(); k++) begin
      big[lo+k] = sb[k];
      sml[lo+k] = ss[k];
    end
  endfunction

  // note one accepted request
  function void note_request(logic signed [31:0] value, logic last);
    logic signed [31:0] chain[$];
    sorted_entry_t e;
    if (loaded.size() < Cap) loaded = {loaded, value};
    else dropped = 1;
    if (!last) return;
    merge_insert_sort(chain);
    foreach (chain[k]) begin
      e.value = chain[k];
      e.last = (k == chain.size() - 1);
      e.ovf = dropped;
      pending_runs = {pending_runs, e};
    end
    loaded = {};
    dropped = 0;
    runs_closed++;
  endfunction

  // check one accepted result against the oldest expectation
  function void check_result(logic signed [31:0] value, logic last, logic ovf);
    sorted_entry_t e;
    results_seen++;
    if (pending_runs.size() == 0) begin
      report_miss("unexpected result", 0, value, 0, last, 0, ovf);
      return;
    end
    e = pending_runs.pop_front();
    if (e.value !== value || e.last !== last || e.ovf !== ovf)
      report_miss("result mismatch", e.value, value, e.last, last, e.ovf, ovf);
  endfunction

  function void report_miss(string what, logic signed [31:0] ev, logic signed [31:0] av,
                            logic el, logic al, logic eo, logic ao);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: value exp %0d got %0d, last exp %0b got %0b, overflow exp %0b got %0b",
               what, ev, av, el, al, eo, ao);
  endfunction
endclass

module merge_insertion_sorter_unit_tb;
  import mis_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] item_value = '0;
  logic item_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] sorted_value;
  logic run_last;
  logic overflow;

  sort_scoreboard board = new();
  int cycles = 0;
  int leftover_errs = 0;

  always #5 clk = ~clk;

  merge_insertion_sorter_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .item_value(item_value), .item_last(item_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .sorted_value(sorted_value), .run_last(run_last), .overflow(overflow)
  );

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_stall) board.note_request(item_value, item_last);
    if (!rst && out_valid && !out_stall) board.check_result(sorted_value, run_last, overflow);
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side stall pattern, with calm stretches
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        g = gap_len();
        out_stall <= (g != 0);
        repeat (g == 0 ? 1 : g) @(negedge clk);
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  // hold one request until accepted; idle gap before it
  task automatic send_request(logic signed [31:0] v, logic last, bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    item_value <= v;
    item_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(logic signed [31:0] vals[$], bit gaps);
    foreach (vals[k]) send_request(vals[k], k == vals.size() - 1, gaps);
    in_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 7)) - 4;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (board.pending_runs.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] vals[$];
    int sent, n;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: single value, extremes, duplicates, odd count, overflow
    send_set('{32'sh80000000}, 0);
    send_set('{32'sh7fffffff, 32'sh80000000}, 0);
    send_set('{5, 5, -1, 5, 0, -1, 32'sh7fffffff}, 0);
    send_set('{3, 1, 4, 1, 5, 9, 2, 6, 5, 3, 3, 8, -7}, 0);
    vals = {};
    for (int k = 0; k < 66; k++) vals = {vals, rand_value()};
    send_set(vals, 1);
    sent = 89;
    // hold off until every expected result is out
    wait_drained();

    // random sets: small ones mostly, near-full and over-full ones seldom
    while (sent < 210) begin
      vals = {};
      case ($urandom_range(0, 9))
        0: n = $urandom_range(60, 68);
        1, 2: n = $urandom_range(1, 3);
        default: n = $urandom_range(4, 16);
      endcase
      for (int k = 0; k < n; k++) vals = {vals, rand_value()};
      send_set(vals, $urandom_range(0, 3) != 0);
      sent += n;
      // let the pipe empty now and then
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(negedge clk);
    leftover_errs = board.pending_runs.size();
    $display("%0d sets closed, %0d sorted values checked, %0d mismatches",
             board.runs_closed, board.results_seen, board.mismatches);
    if (board.mismatches == 0 && leftover_errs == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire
